// ===== src/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types and constants for the rational arithmetic reduce core.
// ----------------------------------------------------------------------------
`default_nettype none
package rar_pkg;

  localparam int OPERAND_BITS_DEF = 16;
  localparam int WORD_BITS        = 32;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MSEL_X = 2'd0,
    MSEL_Y = 2'd1,
    MSEL_D = 2'd2
  } mul_sel_t;

  typedef enum logic [1:0] {
    DSEL_REM = 2'd0,
    DSEL_NUM = 2'd1,
    DSEL_DEN = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MX,
    S_MY,
    S_MD,
    S_COMB,
    S_TEST,
    S_REM,
    S_FIN,
    S_DN,
    S_DD
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     st_x;
    logic     st_y;
    logic     comb;
    logic     div_start;
    div_sel_t div_sel;
    logic     gcd_step;
    logic     st_qn;
    logic     out_en;
    logic     out_err;
  } rar_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic div_done;
  } rar_status_t;

endpackage
`default_nettype wire

// ===== src/rar_div.sv =====
// ----------------------------------------------------------------------------
// rar_div
// Iterative signed divider, truncating quotient, remainder takes dividend sign.
// ----------------------------------------------------------------------------
`default_nettype none
module rar_div
  import rar_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [WORD_BITS-1:0] dividend,
  input  wire logic signed [WORD_BITS-1:0] divisor,
  output logic                             done,
  output logic signed [WORD_BITS-1:0]      quot,
  output logic signed [WORD_BITS-1:0]      rem
);

  localparam int CNT_BITS = $clog2(WORD_BITS);

  logic                 running;
  logic [CNT_BITS-1:0]  cnt;
  logic [WORD_BITS-1:0] q;
  logic [WORD_BITS-1:0] r;
  logic [WORD_BITS-1:0] dv;
  logic                 neg_q;
  logic                 neg_r;
  logic [WORD_BITS:0]   trial;
  logic                 ge;

  assign trial = {r, q[WORD_BITS-1]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(WORD_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= dividend[WORD_BITS-1] ? -dividend : dividend;
      dv    <= divisor[WORD_BITS-1] ? -divisor : divisor;
      r     <= '0;
      neg_q <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
      neg_r <= dividend[WORD_BITS-1];
    end else if (running) begin
      q <= {q[WORD_BITS-2:0], ge};
      r <= ge ? WORD_BITS'(trial - {1'b0, dv}) : trial[WORD_BITS-1:0];
    end
  end

  assign quot = neg_q ? -q : q;
  assign rem  = neg_r ? -r : r;

endmodule
`default_nettype wire

// ===== src/rar_datapath.sv =====
// ----------------------------------------------------------------------------
// rar_datapath
// Operand registers, shared multiplier, Euclid registers, divider, results.
// ----------------------------------------------------------------------------
`default_nettype none
module rar_datapath
  import rar_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rar_cmd_t                       cmd,
  output rar_status_t                         st,
  input  wire logic [1:0]                     command,
  input  wire logic signed [OPERAND_BITS-1:0] num_a,
  input  wire logic signed [OPERAND_BITS-1:0] den_a,
  input  wire logic signed [OPERAND_BITS-1:0] num_b,
  input  wire logic signed [OPERAND_BITS-1:0] den_b,
  output logic signed [WORD_BITS-1:0]         num_out,
  output logic signed [WORD_BITS-1:0]         den_out,
  output logic                                zero_gcd_error,
  output logic                                done
);

  localparam int EXT = WORD_BITS - OPERAND_BITS;

  op_t                  op;
  logic [WORD_BITS-1:0] na, da, nb, db;
  logic [WORD_BITS-1:0] ma, mb, prod, x, y, rn, rd, a, b, qn, comb;
  logic signed [WORD_BITS-1:0] dvd, dvs, quot, rem;
  logic                 div_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= op_t'(command);
      na <= {{EXT{num_a[OPERAND_BITS-1]}}, num_a};
      da <= {{EXT{den_a[OPERAND_BITS-1]}}, den_a};
      nb <= {{EXT{num_b[OPERAND_BITS-1]}}, num_b};
      db <= {{EXT{den_b[OPERAND_BITS-1]}}, den_b};
    end
  end

  always_comb begin
    ma = na;
    mb = db;
    unique case (cmd.mul_sel)
      MSEL_X:  begin ma = na; mb = (op == CMD_MUL) ? nb : db; end
      MSEL_Y:  begin ma = nb; mb = da; end
      MSEL_D:  begin ma = da; mb = (op == CMD_DIV) ? nb : db; end
      default: begin ma = na; mb = db; end
    endcase
  end

  always_comb begin
    unique case (op)
      CMD_ADD: comb = x + y;
      CMD_SUB: comb = x - y;
      default: comb = x;
    endcase
  end

  always_comb begin
    unique case (cmd.div_sel)
      DSEL_REM: begin dvd = b;  dvs = a; end
      DSEL_NUM: begin dvd = rn; dvs = b; end
      DSEL_DEN: begin dvd = rd; dvs = b; end
      default:  begin dvd = b;  dvs = a; end
    endcase
  end

  rar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= ma * mb;
    if (cmd.st_x)   x <= prod;
    if (cmd.st_y)   y <= prod;
    if (cmd.comb) begin
      rn <= comb;
      rd <= prod;
      a  <= comb;
      b  <= prod;
    end else if (cmd.gcd_step) begin
      b <= a;
      a <= rem;
    end
    if (cmd.st_qn) qn <= quot;
    if (cmd.out_en) begin
      num_out <= qn;
      den_out <= quot;
    end else if (cmd.out_err) begin
      num_out <= '0;
      den_out <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done           <= 1'b0;
      zero_gcd_error <= 1'b0;
    end else begin
      done <= cmd.out_en | cmd.out_err;
      if (cmd.out_en | cmd.out_err) zero_gcd_error <= cmd.out_err;
    end
  end

  assign st.a_zero   = (a == '0);
  assign st.b_zero   = (b == '0);
  assign st.div_done = div_done;

endmodule
`default_nettype wire

// ===== src/rar_ctrl.sv =====
// ----------------------------------------------------------------------------
// rar_ctrl
// Sequencer: products, Euclid loop, final reductions, result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module rar_ctrl
  import rar_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire rar_status_t st,
  output rar_cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MX;
        end
      end
      S_MX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_X;
        state_next  = S_MY;
      end
      S_MY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_Y;
        cmd.st_x    = 1'b1;
        state_next  = S_MD;
      end
      S_MD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_D;
        cmd.st_y    = 1'b1;
        state_next  = S_COMB;
      end
      S_COMB: begin
        cmd.comb   = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        if (st.a_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_REM;
          state_next    = S_REM;
        end
      end
      S_REM: begin
        cmd.div_sel = DSEL_REM;
        if (st.div_done) begin
          cmd.gcd_step = 1'b1;
          state_next   = S_TEST;
        end
      end
      S_FIN: begin
        if (st.b_zero) begin
          cmd.out_err = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_NUM;
          state_next    = S_DN;
        end
      end
      S_DN: begin
        cmd.div_sel = DSEL_NUM;
        if (st.div_done) begin
          cmd.st_qn     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_DEN;
          state_next    = S_DD;
        end
      end
      S_DD: begin
        cmd.div_sel = DSEL_DEN;
        if (st.div_done) begin
          cmd.out_en = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/rational_arith_reduce_core.sv =====
// Sequence: three products, then S Euclid remainder steps, each one a full divider
// run, then two divider runs for the final reductions (skipped in the error case).
// One request at a time; start is taken when busy is low, next one at the earliest
// on the done cycle. The receiver cannot stall. Synchronous reset idles the core.
// ----------------------------------------------------------------------------
// rational_arith_reduce_core
// Fraction add/sub/mul/div with Euclid gcd reduction, top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arith_reduce_core
  import rar_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     command,
  input  wire logic signed [OPERAND_BITS-1:0] num_a,
  input  wire logic signed [OPERAND_BITS-1:0] den_a,
  input  wire logic signed [OPERAND_BITS-1:0] num_b,
  input  wire logic signed [OPERAND_BITS-1:0] den_b,
  output logic                                done,
  output logic signed [WORD_BITS-1:0]         num_out,
  output logic signed [WORD_BITS-1:0]         den_out,
  output logic                                zero_gcd_error
);

  rar_cmd_t    cmd;
  rar_status_t st;

  rar_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  rar_datapath #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .command        (command),
    .num_a          (num_a),
    .den_a          (den_a),
    .num_b          (num_b),
    .den_b          (den_b),
    .num_out        (num_out),
    .den_out        (den_out),
    .zero_gcd_error (zero_gcd_error),
    .done           (done)
  );

endmodule
`default_nettype wire

// ===== sim/rational_arith_reduce_core_test.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce_core_test
// Drives random and corner-case fraction requests into the reduce core and
// checks each reduced result against a behavioral Euclid-based predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arith_reduce_core_test;
  import rar_pkg::*;

  typedef struct {
    logic signed [31:0] num;
    logic signed [31:0] den;
    logic               err;
  } frac_res_t;

  class frac_scoreboard;
    frac_res_t pending[$];
    int        errors;

    function automatic logic signed [31:0] quot32(longint n, longint d);
      longint q;
      q = n / d;
      return q[31:0];
    endfunction

    function void note_request(op_t op, logic signed [15:0] na, logic signed [15:0] da,
                               logic signed [15:0] nb, logic signed [15:0] db);
      longint    rn, rd, a, b, r;
      frac_res_t res;
      case (op)
        CMD_ADD: begin rn = na * db + nb * da; rd = da * db; end
        CMD_SUB: begin rn = na * db - nb * da; rd = da * db; end
        CMD_MUL: begin rn = longint'(na) * nb; rd = longint'(da) * db; end
        default: begin rn = longint'(na) * db; rd = longint'(da) * nb; end
      endcase
      rn = longint'($signed(rn[31:0]));
      rd = longint'($signed(rd[31:0]));
      a = rn;
      b = rd;
      while (a != 0) begin
        r = b % a;
        b = a;
        a = r;
      end
      if (b == 0) begin
        res.num = 0; res.den = 0; res.err = 1'b1;
      end else begin
        res.num = quot32(rn, b); res.den = quot32(rd, b); res.err = 1'b0;
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic signed [31:0] n, logic signed [31:0] d, logic e);
      frac_res_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d err=%0b", $time, n, d, e);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (n !== x.num) begin
        $display("%0t: num_out expected %0d actual %0d", $time, x.num, n);
        errors++;
      end
      if (d !== x.den) begin
        $display("%0t: den_out expected %0d actual %0d", $time, x.den, d);
        errors++;
      end
      if (e !== x.err) begin
        $display("%0t: zero_gcd_error expected %0b actual %0b", $time, x.err, e);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         command = '0;
  logic signed [15:0] num_a = '0, den_a = '0, num_b = '0, den_b = '0;
  logic               busy, done, zero_gcd_error;
  logic signed [31:0] num_out, den_out;

  frac_scoreboard sb = new();

  rational_arith_reduce_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
    .done(done), .num_out(num_out), .den_out(den_out),
    .zero_gcd_error(zero_gcd_error)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(num_out, den_out, zero_gcd_error);
  end

  task automatic send_request(op_t op, logic [15:0] na, logic [15:0] da,
                              logic [15:0] nb, logic [15:0] db);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    command <= op;
    num_a   <= na;
    den_a   <= da;
    num_b   <= nb;
    den_b   <= db;
    do @(posedge clk); while (busy);
    sb.note_request(op, na, da, nb, db);
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'($signed($urandom_range(0, 20)) - 10);
      1: return 16'($urandom_range(0, 200));
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8001;
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    // corners: all zero, extremes, -32768 wrap, sign moves to denominator
    for (int k = 0; k < 4; k++) begin
      send_request(op_t'(k), 16'sh7fff, 16'sh8001, 16'sh8001, 16'sh7fff);
      send_request(op_t'(k), 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_request(op_t'(k), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(op_t'(k), 16'hffff, 16'h0003, 16'h0002, 16'hfffb);
      send_request(op_t'(k), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    end
    send_request(CMD_MUL, 16'h0000, 16'h0005, 16'h0003, 16'h0000);
    send_request(CMD_DIV, 16'h0004, 16'h0000, 16'h0000, 16'h0007);
    send_request(CMD_ADD, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
    for (int i = 0; i < 370; i++) begin
      send_request(op_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                   rand_operand(), rand_operand());
    end
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
